// File: rtl/core/pela_pkg.sv
// ============================================================================
// pela_pkg
// Shared types and constants of the packet event log aggregator.
// ============================================================================
package pela_pkg;

    // Table geometry
    localparam int DEPTH  = 256;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths fixed by the interface
    localparam int SLOT_W = 8;
    localparam int FILL_W = 9;
    localparam int STAT_W = 3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MERGED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_APPENDED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd4;

    localparam logic        MODE_CLEAR       = 1'b1;
    localparam logic [31:0] EXCL_SRC_RESET   = 32'h7F00_0001;
    localparam logic [31:0] HITS_MAX         = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              mode;
        logic [31:0]       event_time;
        logic [7:0]        protocol;
        logic [7:0]        verdict;
        logic [7:0]        hook;
        logic [31:0]       source_address;
        logic [31:0]       dest_address;
        logic [15:0]       source_port;
        logic [15:0]       dest_port;
        logic signed [7:0] cause;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] entry_slot;
        logic [31:0]       entry_hits;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

    // Match key of one table entry
    typedef struct packed {
        logic [7:0]        protocol;
        logic [7:0]        verdict;
        logic [7:0]        hook;
        logic [31:0]       source_address;
        logic [31:0]       dest_address;
        logic [15:0]       source_port;
        logic [15:0]       dest_port;
        logic signed [7:0] cause;
    } t_key;

    // One table entry as held in memory
    typedef struct packed {
        logic [31:0] event_time;
        logic [31:0] hits;
        t_key        key;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Datapath to controller
    typedef struct packed {
        logic bypass;    // item resolves without a table search
        logic scan_end;  // search decided (hit, append or full)
        logic out_free;  // output register can take a result
    } t_stat;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic scanning;
        logic push;
    } t_ctrl;

    function automatic t_key key_of(input t_in_item it);
        t_key k;
        k.protocol       = it.protocol;
        k.verdict        = it.verdict;
        k.hook           = it.hook;
        k.source_address = it.source_address;
        k.dest_address   = it.dest_address;
        k.source_port    = it.source_port;
        k.dest_port      = it.dest_port;
        k.cause          = it.cause;
        return k;
    endfunction

endpackage

// File: rtl/core/pela_ram.sv
// ============================================================================
// pela_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module pela_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pela_ctrl.sv
// ============================================================================
// pela_ctrl
// Item sequencer: accept, table search, result hand-off.
// ============================================================================
module pela_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pela_pkg::t_stat i_stat,
    output pela_pkg::t_ctrl o_ctrl
);

    pela_pkg::t_state r_state;
    pela_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pela_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pela_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.bypass ? pela_pkg::S_DONE : pela_pkg::S_SCAN;
                end
            end
            pela_pkg::S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = pela_pkg::S_DONE;
                end
            end
            pela_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = pela_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pela_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl = '0;
        case (r_state)
            pela_pkg::S_IDLE: o_ctrl.in_ready = 1'b1;
            pela_pkg::S_SCAN: o_ctrl.scanning = 1'b1;
            pela_pkg::S_DONE: o_ctrl.push     = i_stat.out_free;
            default:          o_ctrl          = '0;
        endcase
    end

endmodule

// File: rtl/core/packet_event_log_aggregator_top.sv
// ============================================================================
// packet_event_log_aggregator_top
// Firewall event aggregation table: merges events with equal flow keys,
// appends new flows, and reports one result item per input item.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata (excluded src)
//
//  A log item is searched against the N valid entries: the search walks the
//  entry memory one read per cycle in fill order, and a match in slot i ends
//  it there. Clear and excluded-source items skip the search. One item is in
//  work at a time; the next item is accepted only from the idle state, after
//  its result has moved to the result register. The result register lets the
//  next item be accepted while a result still waits on i_out_ready. Reset is
//  synchronous and empties the table at once (fill count to zero); only
//  entries below the fill count are ever read.
//
module packet_event_log_aggregator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pela_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pela_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    pela_pkg::t_ctrl ctl;
    pela_pkg::t_stat stat;

    // Registers
    logic [31:0]               r_excl_src;
    pela_pkg::t_in_item        r_item;
    logic [pela_pkg::CNT_W-1:0] r_used;
    logic [pela_pkg::CNT_W-1:0] r_rd_cnt;
    logic                      r_cmp_vld;
    logic [pela_pkg::IDX_W-1:0] r_cmp_idx;
    pela_pkg::t_out_item       r_res;
    pela_pkg::t_out_item       r_out;
    logic                      r_out_vld;

    // Combinational
    logic                      in_acc;
    logic                      is_clear;
    logic                      is_ign;
    logic                      rd_en;
    logic                      hit;
    logic                      exhausted;
    logic                      tbl_full;
    pela_pkg::t_entry          rd_entry;
    pela_pkg::t_entry          wr_entry;
    logic                      wr_en;
    logic [pela_pkg::IDX_W-1:0] wr_addr;
    logic [31:0]               hits_inc;

    assign in_acc   = i_in_valid && ctl.in_ready;
    assign is_clear = (i_in_data.mode == pela_pkg::MODE_CLEAR);
    assign is_ign   = !is_clear && (i_in_data.source_address == r_excl_src);

    // Read the next entry while it lies below the fill count
    assign rd_en     = ctl.scanning && (r_rd_cnt < r_used);
    assign hit       = r_cmp_vld && (rd_entry.key == pela_pkg::key_of(r_item));
    assign exhausted = !r_cmp_vld && !rd_en;
    assign tbl_full  = (r_used == pela_pkg::CNT_W'(pela_pkg::DEPTH));
    assign hits_inc  = (rd_entry.hits == pela_pkg::HITS_MAX) ? rd_entry.hits
                                                             : rd_entry.hits + 32'd1;

    assign stat.bypass   = is_clear || is_ign;
    assign stat.scan_end = ctl.scanning && (hit || exhausted);
    assign stat.out_free = !r_out_vld || i_out_ready;

    // Write back on a hit, or append at the fill count on a miss with room
    always_comb begin
        wr_en               = 1'b0;
        wr_addr             = r_cmp_idx;
        wr_entry.event_time = r_item.event_time;
        wr_entry.hits       = hits_inc;
        wr_entry.key        = pela_pkg::key_of(r_item);
        if (ctl.scanning && hit) begin
            wr_en = 1'b1;
        end else if (ctl.scanning && exhausted && !tbl_full) begin
            wr_en         = 1'b1;
            wr_addr       = r_used[pela_pkg::IDX_W-1:0];
            wr_entry.hits = 32'd1;
        end
    end

    pela_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctl)
    );

    pela_ram #(
        .WIDTH ($bits(pela_pkg::t_entry)),
        .DEPTH (pela_pkg::DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_rd_cnt[pela_pkg::IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl_src <= pela_pkg::EXCL_SRC_RESET;
        end else if (i_cfg_we) begin
            r_excl_src <= i_cfg_wdata;
        end
    end

    // Control state: fill count, search pointer, result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rd_cnt  <= '0;
                r_cmp_vld <= 1'b0;
                if (is_clear) begin
                    r_used <= '0;
                end
            end else if (ctl.scanning) begin
                if (rd_en) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
                // Drop the pipelined compare once the search has decided
                r_cmp_vld <= rd_en && !hit;
                if (exhausted && !tbl_full) begin
                    r_used <= r_used + 1'b1;
                end
            end
            if (ctl.push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item           <= i_in_data;
            r_res.entry_slot <= '0;
            r_res.entry_hits <= '0;
            if (is_clear) begin
                r_res.status     <= pela_pkg::STAT_CLEARED;
                r_res.fill_level <= '0;
            end else begin
                r_res.status     <= pela_pkg::STAT_IGNORED;
                r_res.fill_level <= pela_pkg::FILL_W'(r_used);
            end
        end else if (ctl.scanning) begin
            if (hit) begin
                r_res.status     <= pela_pkg::STAT_MERGED;
                r_res.entry_slot <= pela_pkg::SLOT_W'(r_cmp_idx);
                r_res.entry_hits <= hits_inc;
                r_res.fill_level <= pela_pkg::FILL_W'(r_used);
            end else if (exhausted && tbl_full) begin
                r_res.status     <= pela_pkg::STAT_FULL;
                r_res.entry_slot <= '0;
                r_res.entry_hits <= '0;
                r_res.fill_level <= pela_pkg::FILL_W'(r_used);
            end else if (exhausted) begin
                r_res.status     <= pela_pkg::STAT_APPENDED;
                r_res.entry_slot <= pela_pkg::SLOT_W'(r_used[pela_pkg::IDX_W-1:0]);
                r_res.entry_hits <= 32'd1;
                r_res.fill_level <= pela_pkg::FILL_W'(r_used + 1'b1);
            end
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_cnt[pela_pkg::IDX_W-1:0];
        end
        if (ctl.push) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = ctl.in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/pela_chk.sv
// ============================================================================
// pela_chk
// Port-level checks of the packet event log aggregator.
// ============================================================================
module pela_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pela_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= pela_pkg::STAT_CLEARED)
        else $error("unknown status code");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.fill_level <= pela_pkg::FILL_W'(pela_pkg::DEPTH))
        else $error("fill level beyond table depth");

    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == pela_pkg::STAT_CLEARED
        |-> o_out_data.entry_slot == '0 && o_out_data.entry_hits == '0
            && o_out_data.fill_level == '0)
        else $error("clear result not empty");

    a_appended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == pela_pkg::STAT_APPENDED
        |-> o_out_data.entry_hits == 32'd1
            && o_out_data.fill_level
               == pela_pkg::FILL_W'(o_out_data.entry_slot) + 1'b1)
        else $error("append result inconsistent");

endmodule

bind packet_event_log_aggregator_top pela_chk u_pela_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
